>>> sv/rdp_pkg.sv
// Package: shared types, constants and codes for the reuse distance profiler.
package rdp_pkg;
	localparam int STACK_DEPTH = 64;
	localparam int ADDRESS_BITS = 64;
	localparam int COUNT_BITS = 32;
	localparam int POS_BITS = $clog2(STACK_DEPTH);
	localparam int FILL_BITS = $clog2(STACK_DEPTH + 1);
	localparam int NUM_BINS = 8;
	localparam int COLD_BIN = 7;
	localparam int CNT_W = (COUNT_BITS < 32) ? COUNT_BITS : 32;
	localparam logic [5:0] DIST_MAX = 6'd63;

	typedef enum logic [1:0] {
		ACT_READ = 2'd0,
		ACT_WRITE = 2'd1,
		ACT_FINISH = 2'd2,
		ACT_NONE = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ACCESS,
		ST_SCAN,
		ST_REPORT,
		ST_WAIT
	} state_t;

	typedef struct packed {
		logic load;
		logic access;
		logic scan;
		logic report;
		logic clear;
	} cmd_t;

	typedef struct packed {
		logic [1:0] action;
		logic scan_done;
		logic report_done;
	} sts_t;

	typedef struct packed {
		logic is_report;
		logic [5:0] distance;
		logic is_cold;
		logic is_write;
		logic [2:0] bin_index;
		logic [31:0] bin_count;
		logic [39:0] distance_sum;
		logic [31:0] access_count;
		logic [5:0] max_distance;
		logic [31:0] stream_count;
		logic last;
	} result_t;

	function automatic logic [2:0] bin_of(input logic [5:0] d);
		logic [2:0] b;
		b = 3'd0;
		for (int i = 0; i < 6; i++)
			if (d[i]) b = 3'(i + 1);
		return b;
	endfunction

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		return (&v) ? v : v + 1'b1;
	endfunction
endpackage

>>> sv/rdp_if.sv
// Interfaces: access input channel, result output channel, config channel.
interface rdp_in_if;
	import rdp_pkg::*;
	logic valid;
	logic ready;
	logic [1:0] action;
	logic [63:0] address;
	modport source(output valid, action, address, input ready);
	modport sink(input valid, action, address, output ready);
endinterface

interface rdp_out_if;
	import rdp_pkg::*;
	logic valid;
	logic ready;
	result_t data;
	modport source(output valid, data, input ready);
	modport sink(input valid, data, output ready);
endinterface

interface rdp_cfg_if;
	logic valid;
	logic ready;
	logic data;
	modport source(output valid, data, input ready);
	modport sink(input valid, data, output ready);
endinterface

>>> sv/reuse_distance_profiler_top.sv
// Top level: reuse distance profiler with LRU stack and log2 histogram.
// Channels: in_ch carries action and address, out_ch carries result items,
// cfg_ch writes treat_cold_as_one (reset value 1), taken at any time.
// A read or write is first registered, then the parallel compare over the
// stack and the shift update run once no earlier result is waiting; its
// single result stands in the output register the cycle after the update.
// Unknown actions are registered and give nothing.
// Finish scans the stack one entry per cycle to count unreused entries,
// then sends eight report transfers, one per cycle while the receiver takes
// them, and clears statistics and the stack.
// Reset empties the stack and clears all counters.
// When the receiver stalls, the block holds its result and waits; a new
// item is taken while the last result is still waiting to be taken.
module reuse_distance_profiler_top import rdp_pkg::*; (
	input logic clk,
	input logic arst_n,
	rdp_in_if.sink in_ch,
	rdp_out_if.source out_ch,
	rdp_cfg_if.sink cfg_ch
);
	cmd_t cmd;
	sts_t sts;
	logic cold_one_q;

	assign cfg_ch.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) cold_one_q <= 1'b1;
		else if (cfg_ch.valid) cold_one_q <= cfg_ch.data;
	end

	rdp_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready),
		.sts(sts), .cmd(cmd)
	);

	rdp_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.in_action(in_ch.action), .in_address(in_ch.address),
		.cold_one(cold_one_q), .res(out_ch.data)
	);
endmodule

>>> sv/rdp_datapath.sv
// Datapath: LRU stack, statistics counters and result register.
module rdp_datapath import rdp_pkg::*; (
	input logic clk,
	input logic arst_n,
	input cmd_t cmd,
	output sts_t sts,
	input logic [1:0] in_action,
	input logic [63:0] in_address,
	input logic cold_one,
	output result_t res
);
	logic [ADDRESS_BITS-1:0] addr_q;
	logic [1:0] act_q;
	logic [ADDRESS_BITS-1:0] stk_addr_q [STACK_DEPTH];
	logic stk_reu_q [STACK_DEPTH];
	logic [FILL_BITS-1:0] fill_q;
	logic [CNT_W-1:0] bins_q [NUM_BINS];
	logic [39:0] sum_q;
	logic [CNT_W-1:0] cnt_q;
	logic [5:0] max_q;
	logic [CNT_W-1:0] strm_q;
	logic [CNT_W-1:0] scan_strm_q;
	logic [POS_BITS-1:0] scan_q;
	logic [2:0] rep_q;

	// Parallel match over the valid part of the stack.
	logic found;
	logic [POS_BITS-1:0] pos;
	always_comb begin
		found = 1'b0;
		pos = '0;
		for (int i = STACK_DEPTH - 1; i >= 0; i--) begin
			if (FILL_BITS'(i) < fill_q && stk_addr_q[i] == addr_q) begin
				found = 1'b1;
				pos = POS_BITS'(i);
			end
		end
	end

	logic [5:0] dist_hit;
	assign dist_hit = (32'(pos) > 32'(DIST_MAX)) ? DIST_MAX : 6'(pos);
	logic full;
	assign full = (fill_q == FILL_BITS'(STACK_DEPTH));

	logic [5:0] cnt_d;
	logic [2:0] cnt_bin;
	logic do_count, do_cold7;
	always_comb begin
		do_count = 1'b0;
		do_cold7 = 1'b0;
		cnt_d = 6'd0;
		cnt_bin = 3'd0;
		if (act_q == ACT_READ) begin
			if (found) begin
				do_count = 1'b1;
				cnt_d = dist_hit;
				cnt_bin = bin_of(dist_hit);
			end else if (cold_one) begin
				do_count = 1'b1;
				cnt_d = 6'd1;
				cnt_bin = 3'd1;
			end else begin
				do_cold7 = 1'b1;
				cnt_bin = 3'(COLD_BIN);
			end
		end
	end

	logic [40:0] sum_add;
	assign sum_add = {1'b0, sum_q} + 41'(cnt_d);
	logic [39:0] sum_n;
	assign sum_n = sum_add[40] ? '1 : sum_add[39:0];
	logic [CNT_W-1:0] bin_n, cnt_n, strm_n;
	assign bin_n = sat_inc(bins_q[cnt_bin]);
	assign cnt_n = do_count ? sat_inc(cnt_q) : cnt_q;
	logic [5:0] max_n;
	assign max_n = (do_count && cnt_d > max_q) ? cnt_d : max_q;
	always_comb begin
		strm_n = strm_q;
		if (act_q == ACT_WRITE && found) strm_n = sat_inc(strm_q);
		if (act_q == ACT_READ && !found && full && !stk_reu_q[STACK_DEPTH-1])
			strm_n = sat_inc(strm_q);
	end

	assign sts.action = act_q;
	assign sts.scan_done = (FILL_BITS'(scan_q) + 1'b1 >= fill_q) ||
		(32'(scan_q) == STACK_DEPTH - 1);
	assign sts.report_done = (rep_q == 3'(NUM_BINS - 1));

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q <= in_action;
			addr_q <= in_address[ADDRESS_BITS-1:0];
		end
		if (cmd.access && act_q == ACT_READ) begin
			for (int i = 1; i < STACK_DEPTH; i++) begin
				if ((found && POS_BITS'(i) <= pos) || !found) begin
					stk_addr_q[i] <= stk_addr_q[i-1];
					stk_reu_q[i] <= stk_reu_q[i-1];
				end
			end
			stk_addr_q[0] <= addr_q;
			stk_reu_q[0] <= found;
		end
		if (cmd.access && act_q == ACT_WRITE && found) begin
			for (int i = 0; i < STACK_DEPTH - 1; i++) begin
				if (POS_BITS'(i) >= pos) begin
					stk_addr_q[i] <= stk_addr_q[i+1];
					stk_reu_q[i] <= stk_reu_q[i+1];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			for (int i = 0; i < NUM_BINS; i++) bins_q[i] <= '0;
			sum_q <= '0;
			cnt_q <= '0;
			max_q <= '0;
			strm_q <= '0;
			scan_strm_q <= '0;
			scan_q <= '0;
			rep_q <= '0;
		end else begin
			if (cmd.load) begin
				scan_q <= '0;
				rep_q <= '0;
				scan_strm_q <= strm_q;
			end
			if (cmd.access) begin
				strm_q <= strm_n;
				if (act_q == ACT_WRITE && found) fill_q <= fill_q - 1'b1;
				if (act_q == ACT_READ && !found && !full) fill_q <= fill_q + 1'b1;
				if (do_count || do_cold7) bins_q[cnt_bin] <= bin_n;
				if (do_count) begin
					sum_q <= sum_n;
					cnt_q <= cnt_n;
					max_q <= max_n;
				end
			end
			if (cmd.scan) begin
				// One stack entry per cycle; unreused entries add to streams.
				if (FILL_BITS'(scan_q) < fill_q && !stk_reu_q[scan_q])
					scan_strm_q <= sat_inc(scan_strm_q);
				if (!sts.scan_done) scan_q <= scan_q + 1'b1;
			end
			if (cmd.report) rep_q <= rep_q + 1'b1;
			if (cmd.clear) begin
				fill_q <= '0;
				for (int i = 0; i < NUM_BINS; i++) bins_q[i] <= '0;
				sum_q <= '0;
				cnt_q <= '0;
				max_q <= '0;
				strm_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.access) begin
			res.is_report <= 1'b0;
			res.distance <= cnt_d;
			res.is_cold <= (act_q == ACT_READ) && !found;
			res.is_write <= (act_q == ACT_WRITE);
			res.bin_index <= cnt_bin;
			res.bin_count <= (act_q == ACT_READ) ? 32'(bin_n) : 32'd0;
			res.distance_sum <= do_count ? sum_n : sum_q;
			res.access_count <= 32'(cnt_n);
			res.max_distance <= max_n;
			res.stream_count <= 32'(strm_n);
			res.last <= 1'b1;
		end
		if (cmd.report) begin
			res.is_report <= 1'b1;
			res.distance <= 6'd0;
			res.is_cold <= 1'b0;
			res.is_write <= 1'b0;
			res.bin_index <= rep_q;
			res.bin_count <= 32'(bins_q[rep_q]);
			res.distance_sum <= sum_q;
			res.access_count <= 32'(cnt_q);
			res.max_distance <= max_q;
			res.stream_count <= 32'(scan_strm_q);
			res.last <= sts.report_done;
		end
	end
endmodule

>>> sv/rdp_ctrl.sv
// Controller: sequences access, stack scan and report transfers.
module rdp_ctrl import rdp_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input logic out_ready,
	input sts_t sts,
	output cmd_t cmd
);
	state_t state_q, state_d;
	logic ov_q, ov_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ov_q <= 1'b0;
		end else begin
			state_q <= state_d;
			ov_q <= ov_d;
		end
	end

	assign out_valid = ov_q;
	logic free;
	assign free = !ov_q || out_ready;

	always_comb begin
		state_d = state_q;
		ov_d = ov_q && !out_ready;
		cmd = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = ST_ACCESS;
				end
			end
			ST_ACCESS: begin
				if (sts.action == ACT_NONE) state_d = ST_IDLE;
				else if (sts.action == ACT_FINISH) state_d = ST_SCAN;
				else if (free) begin
					cmd.access = 1'b1;
					ov_d = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.scan_done) state_d = ST_REPORT;
			end
			ST_REPORT: begin
				if (free) begin
					cmd.report = 1'b1;
					ov_d = 1'b1;
					if (sts.report_done) state_d = ST_WAIT;
				end
			end
			ST_WAIT: begin
				cmd.clear = 1'b1;
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end
endmodule

>>> test/reuse_distance_profiler_top_test.sv
// Testbench for the reuse distance profiler: queued stimulus, LRU-stack predictor, field checks.
`timescale 1ns / 100ps

module reuse_distance_profiler_top_test;
	import rdp_pkg::*;

	typedef struct {
		action_t act;
		logic [63:0] addr;
	} access_t;

	logic clk;
	logic arst_n;
	rdp_in_if in_ch();
	rdp_out_if out_ch();
	rdp_cfg_if cfg_ch();

	reuse_distance_profiler_top u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch.sink),
		.out_ch(out_ch.source),
		.cfg_ch(cfg_ch.sink)
	);

	access_t pending_accesses[$];
	result_t expected_results[$];
	int send_idle_pct;
	int recv_stall_pct;
	int mismatches;
	int cycle_count;
	bit cfg_req;
	logic cfg_value;
	logic [63:0] addr_pool[16];
	bit in_taken;
	bit cfg_taken;

	// Predictor state.
	logic [63:0] lru_addr[STACK_DEPTH];
	bit lru_reused[STACK_DEPTH];
	int lru_fill;
	logic [31:0] hist[NUM_BINS];
	logic [39:0] dist_sum;
	logic [31:0] read_total;
	logic [5:0] dist_peak;
	logic [31:0] streams;
	bit cold_as_one;

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	function automatic logic [31:0] bump(input logic [31:0] v);
		return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
	endfunction

	function automatic logic [2:0] log2_bin(input logic [5:0] d);
		logic [2:0] b;
		b = 3'd0;
		for (int i = 0; i < 6; i++)
			if (d[i]) b = 3'(i + 1);
		return b;
	endfunction

	function automatic result_t blank_result();
		result_t r;
		r = '0;
		r.distance_sum = dist_sum;
		r.access_count = read_total;
		r.max_distance = dist_peak;
		r.stream_count = streams;
		r.last = 1'b1;
		return r;
	endfunction

	task automatic tally(input logic [5:0] d, input logic [2:0] b);
		hist[b] = bump(hist[b]);
		dist_sum = (dist_sum + 40'(d) < dist_sum) ? 40'hFF_FFFF_FFFF : dist_sum + 40'(d);
		read_total = bump(read_total);
		if (d > dist_peak) dist_peak = d;
	endtask

	task automatic clear_profile();
		lru_fill = 0;
		for (int i = 0; i < NUM_BINS; i++) hist[i] = '0;
		dist_sum = '0;
		read_total = '0;
		dist_peak = '0;
		streams = '0;
	endtask

	task automatic predict_access(input access_t a);
		int pos;
		logic [31:0] total_streams;
		logic [5:0] d;
		logic [2:0] b;
		result_t r;
		pos = -1;
		if (a.act == ACT_NONE) return;
		if (a.act == ACT_FINISH) begin
			total_streams = streams;
			for (int i = 0; i < lru_fill; i++)
				if (!lru_reused[i]) total_streams = bump(total_streams);
			for (int i = 0; i < NUM_BINS; i++) begin
				r = blank_result();
				r.is_report = 1'b1;
				r.bin_index = 3'(i);
				r.bin_count = hist[i];
				r.stream_count = total_streams;
				r.last = (i == NUM_BINS - 1);
				expected_results.insert(expected_results.size(), r);
			end
			clear_profile();
			return;
		end
		for (int i = 0; i < lru_fill; i++)
			if (pos < 0 && lru_addr[i] == a.addr) pos = i;
		if (a.act == ACT_WRITE) begin
			if (pos >= 0) begin
				for (int i = pos; i + 1 < lru_fill; i++) begin
					lru_addr[i] = lru_addr[i + 1];
					lru_reused[i] = lru_reused[i + 1];
				end
				lru_fill--;
				streams = bump(streams);
			end
			r = blank_result();
			r.is_write = 1'b1;
			expected_results.insert(expected_results.size(), r);
			return;
		end
		if (pos >= 0) begin
			d = 6'(pos);
			b = log2_bin(d);
			for (int i = pos; i > 0; i--) begin
				lru_addr[i] = lru_addr[i - 1];
				lru_reused[i] = lru_reused[i - 1];
			end
			lru_addr[0] = a.addr;
			lru_reused[0] = 1'b1;
			tally(d, b);
			r = blank_result();
			r.distance = d;
			r.bin_index = b;
			r.bin_count = hist[b];
			expected_results.insert(expected_results.size(), r);
			return;
		end
		// Cold read: a full stack drops its oldest entry first.
		if (lru_fill >= STACK_DEPTH) begin
			if (!lru_reused[STACK_DEPTH - 1]) streams = bump(streams);
			lru_fill = STACK_DEPTH - 1;
		end
		for (int i = lru_fill; i > 0; i--) begin
			lru_addr[i] = lru_addr[i - 1];
			lru_reused[i] = lru_reused[i - 1];
		end
		lru_addr[0] = a.addr;
		lru_reused[0] = 1'b0;
		lru_fill++;
		if (cold_as_one) begin
			tally(6'd1, 3'd1);
			r = blank_result();
			r.distance = 6'd1;
			r.bin_index = 3'd1;
		end else begin
			hist[COLD_BIN] = bump(hist[COLD_BIN]);
			r = blank_result();
			r.bin_index = 3'(COLD_BIN);
		end
		r.is_cold = 1'b1;
		r.bin_count = r.bin_index == 3'(COLD_BIN) ? hist[COLD_BIN] : hist[1];
		expected_results.insert(expected_results.size(), r);
	endtask

	// Input driver: a transfer that has not yet been taken is held.
	always @(negedge clk) begin
		if (in_ch.valid && !in_taken) begin
		end else if (pending_accesses.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
			in_ch.valid <= 1'b1;
			in_ch.action <= pending_accesses[0].act;
			in_ch.address <= pending_accesses[0].addr;
		end else begin
			in_ch.valid <= 1'b0;
		end
		in_taken = 1'b0;
		out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
		if (cfg_ch.valid && !cfg_taken) begin
		end else if (cfg_req) begin
			cfg_ch.valid <= 1'b1;
			cfg_ch.data <= cfg_value;
		end else begin
			cfg_ch.valid <= 1'b0;
		end
		cfg_taken = 1'b0;
	end

	// Acceptance and result monitor.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (in_ch.valid && in_ch.ready) begin
			predict_access(pending_accesses.pop_front());
			in_taken = 1'b1;
		end
		if (cfg_ch.valid && cfg_ch.ready) begin
			cold_as_one = cfg_ch.data;
			cfg_req = 1'b0;
			cfg_taken = 1'b1;
		end
		if (out_ch.valid && out_ch.ready) begin
			if (expected_results.size() == 0) begin
				$error("unexpected result transfer");
				mismatches++;
			end else begin
				result_t e, g;
				e = expected_results.pop_front();
				g = out_ch.data;
				if (g.is_report !== e.is_report) begin
					$error("is_report exp %0d got %0d", e.is_report, g.is_report); mismatches++; end
				if (g.distance !== e.distance) begin
					$error("distance exp %0d got %0d", e.distance, g.distance); mismatches++; end
				if (g.is_cold !== e.is_cold) begin
					$error("is_cold exp %0d got %0d", e.is_cold, g.is_cold); mismatches++; end
				if (g.is_write !== e.is_write) begin
					$error("is_write exp %0d got %0d", e.is_write, g.is_write); mismatches++; end
				if (g.bin_index !== e.bin_index) begin
					$error("bin_index exp %0d got %0d", e.bin_index, g.bin_index); mismatches++; end
				if (g.bin_count !== e.bin_count) begin
					$error("bin_count exp %0d got %0d", e.bin_count, g.bin_count); mismatches++; end
				if (g.distance_sum !== e.distance_sum) begin
					$error("distance_sum exp %0d got %0d", e.distance_sum, g.distance_sum);
					mismatches++;
				end
				if (g.access_count !== e.access_count) begin
					$error("access_count exp %0d got %0d", e.access_count, g.access_count);
					mismatches++;
				end
				if (g.max_distance !== e.max_distance) begin
					$error("max_distance exp %0d got %0d", e.max_distance, g.max_distance);
					mismatches++;
				end
				if (g.stream_count !== e.stream_count) begin
					$error("stream_count exp %0d got %0d", e.stream_count, g.stream_count);
					mismatches++;
				end
				if (g.last !== e.last) begin
					$error("last exp %0d got %0d", e.last, g.last); mismatches++; end
			end
		end
		if (cycle_count > 400000) begin
			$display("Mismatches found");
			$finish;
		end
	end

	task automatic push(input action_t act, input logic [63:0] addr);
		access_t a;
		a.act = act;
		a.addr = addr;
		pending_accesses.insert(pending_accesses.size(), a);
	endtask

	task automatic drain();
		while (pending_accesses.size() > 0 || expected_results.size() > 0) @(posedge clk);
		// A trailing unknown action may still be in flight.
		repeat (4) @(posedge clk);
	endtask

	task automatic write_cfg(input logic v);
		cfg_value = v;
		cfg_req = 1'b1;
		while (cfg_req) @(posedge clk);
	endtask

	// Mostly reads and writes over a small address pool, with finishes and noise.
	task automatic random_phase(input int n, input int idle, input int stall);
		int k;
		send_idle_pct = idle;
		recv_stall_pct = stall;
		for (int i = 0; i < n; i++) begin
			k = $urandom_range(99);
			if (k < 2) push(ACT_FINISH, {$urandom, $urandom});
			else if (k < 4) push(ACT_NONE, {$urandom, $urandom});
			else if (k < 20) push(ACT_WRITE, addr_pool[$urandom_range(15)]);
			else if (k < 30) push(ACT_READ, {$urandom, $urandom});
			else push(ACT_READ, addr_pool[$urandom_range(15)]);
		end
		drain();
	endtask

	initial begin
		in_ch.valid = 1'b0;
		in_ch.action = ACT_READ;
		in_ch.address = '0;
		out_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.data = 1'b0;
		cfg_req = 1'b0;
		in_taken = 1'b0;
		cfg_taken = 1'b0;
		cycle_count = 0;
		mismatches = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		cold_as_one = 1'b1;
		clear_profile();
		for (int i = 0; i < 16; i++) addr_pool[i] = {$urandom, $urandom};
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: address extremes, reuse, writes, unknown action, eviction, finish.
		push(ACT_READ, 64'h0);
		push(ACT_READ, 64'hFFFF_FFFF_FFFF_FFFF);
		push(ACT_READ, 64'h0);
		push(ACT_WRITE, 64'hFFFF_FFFF_FFFF_FFFF);
		push(ACT_WRITE, 64'h1234);
		push(ACT_NONE, 64'h0);
		push(ACT_READ, 64'hAAAA_AAAA_5555_5555);
		push(ACT_READ, 64'h5555_5555_AAAA_AAAA);
		push(ACT_READ, 64'h0);
		push(ACT_FINISH, 64'h0);
		drain();
		write_cfg(1'b0);
		push(ACT_READ, 64'h10);
		push(ACT_READ, 64'h10);
		push(ACT_WRITE, 64'h10);
		push(ACT_FINISH, 64'hFFFF_FFFF_FFFF_FFFF);
		drain();
		write_cfg(1'b1);
		// Fill past the stack depth, then reuse the deepest entry for the longest distance.
		for (int i = 0; i < 70; i++) push(ACT_READ, 64'(i) << 3);
		push(ACT_READ, 64'(6) << 3);
		push(ACT_READ, 64'(8) << 3);
		push(ACT_FINISH, 64'h0);
		drain();

		random_phase(90, 0, 0);
		write_cfg(1'b0);
		random_phase(90, 60, 0);
		write_cfg(1'b1);
		random_phase(90, 0, 60);
		write_cfg(1'b0);
		random_phase(80, 25, 25);
		push(ACT_FINISH, 64'h0);
		drain();
		repeat (20) @(posedge clk);
		if (mismatches == 0 && expected_results.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule

>>> sim.f
sv/rdp_pkg.sv
sv/rdp_if.sv
sv/rdp_datapath.sv
sv/rdp_ctrl.sv
sv/reuse_distance_profiler_top.sv
test/reuse_distance_profiler_top_test.sv
